[sv/sapm_pkg.sv]
package sapm_pkg;

  // Item field widths
  localparam int CMD_W      = 2;
  localparam int CNT_W      = 2;
  localparam int BYTE_W     = 8;
  localparam int POS_W      = 16;
  localparam int HALF_W     = 16;
  localparam int SETUP_W    = 10;
  localparam int STEPS_W    = 19;

  // Stream packing
  localparam int IN_DATA_W  = 24;  // cnt(2) + two bytes, padded to bytes
  localparam int IN_USER_W  = CMD_W;
  localparam int OUT_DATA_W = 24;  // step, dir, moving, position, padded to bytes
  localparam int OUT_USER_W = 2;

  // Config port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HALF  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SETUP = 2'd1;

  localparam logic [HALF_W-1:0]  HALF_RST  = 16'd500;
  localparam logic [SETUP_W-1:0] SETUP_RST = 10'd20;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FRAME = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Step count = (40*mag + 4) / 9, division by reciprocal multiply.
  // MAGIC = ceil(2^27 / 9); exact for all dividends below 2^27.
  localparam int MAG_W       = 16;
  localparam int SCALED_W    = 21;
  localparam int MAGIC_W     = 24;
  localparam int DIV9_SHIFT  = 27;
  localparam int PROD_W      = SCALED_W + MAGIC_W;
  localparam int QUOT_W      = PROD_W - DIV9_SHIFT;
  localparam logic [MAGIC_W-1:0] DIV9_MAGIC = 24'd14913081;

endpackage

[sv/stepper_absolute_position_mover.sv]
// Channel  | Dir | Ports                          | Contents
// ---------+-----+--------------------------------+--------------------------------------
// in       | in  | in_tvalid/in_tready            | tuser: cmd; tdata: byte_count,
//          |     | in_tdata[23:0], in_tuser[1:0]  |   first_byte, second_byte
// out      | out | out_tvalid/out_tready          | tdata: step_level, dir_level, moving,
//          |     | out_tdata[23:0], out_tuser[1:0]|   position; tuser: read_reply, frame_taken
// cfg      | in  | cfg_valid/cfg_ready            | cfg_index selects register, cfg_data
//
// One request per cycle while out_tready is high. Requests pass an input
// register, then the state update, then the result register.
// The step count divide (multiply by reciprocal of 9) runs in the cycle after
// a move starts, off the request path; the count is first used two ticks later.
// Reset (rst_n low, synchronous) clears state and drops any request in flight.
// A stalled result holds the pipe; the input register still takes one request.
// cfg_ready is always high; writes are taken at once.
module stepper_absolute_position_mover
  import sapm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_DATA_W-1:0]   in_tdata,   // [1:0] byte_count, [9:2] first_byte,
                                             // [17:10] second_byte, rest zero
  input  logic [IN_USER_W-1:0]   in_tuser,   // [1:0] cmd
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata,  // [0] step_level, [1] dir_level,
                                             // [2] moving, [18:3] position, rest zero
  output logic [OUT_USER_W-1:0]  out_tuser,  // [0] read_reply, [1] frame_taken
  // config writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [1:0] {PH_IDLE, PH_SETUP, PH_HIGH, PH_LOW} phase_t;

  // config registers
  logic [HALF_W-1:0]  half_r;
  logic [SETUP_W-1:0] setup_r;

  // input register
  logic               in_v_r;
  logic [CMD_W-1:0]   cmd_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [BYTE_W-1:0]  b0_r;
  logic [BYTE_W-1:0]  b1_r;

  // controller state
  phase_t             phase_r, phase_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [POS_W-1:0]   pend_r, pend_nxt;
  logic               pending_r, pending_nxt;
  logic [HALF_W-1:0]  tick_r, tick_nxt;
  logic [STEPS_W-1:0] steps_r, steps_nxt;
  logic               dir_r, dir_nxt;
  logic               step_r, step_nxt;

  // step count calculation
  logic               calc_r, calc_nxt;
  logic [MAG_W-1:0]   mag_r, mag_nxt;
  logic [SCALED_W-1:0] scaled;
  logic [PROD_W-1:0]  prod;

  // result register
  logic               out_v_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [OUT_USER_W-1:0] out_user_r, out_user_nxt;

  logic               advance;
  logic [HALF_W-1:0]  half_eff;
  logic [POS_W-1:0]   delta;
  logic [HALF_W-1:0]  tick_dec;
  logic [STEPS_W-1:0] steps_dec;
  logic               reply;
  logic               taken;

  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // half period of zero behaves as one
  assign half_eff = (half_r == '0) ? HALF_W'(1) : half_r;
  assign delta    = pend_r - pos_r;
  assign tick_dec = (tick_r != '0) ? tick_r - HALF_W'(1) : '0;
  assign steps_dec = (steps_r != '0) ? steps_r - STEPS_W'(1) : '0;

  // 40*mag + 4 as shifts, then divide by 9
  assign scaled = (SCALED_W'(mag_r) << 5) + (SCALED_W'(mag_r) << 3) + SCALED_W'(4);
  assign prod   = PROD_W'(scaled) * PROD_W'(DIV9_MAGIC);

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    pend_nxt    = pend_r;
    pending_nxt = pending_r;
    tick_nxt    = tick_r;
    steps_nxt   = steps_r;
    dir_nxt     = dir_r;
    step_nxt    = step_r;
    calc_nxt    = 1'b0;
    mag_nxt     = mag_r;
    reply       = 1'b0;
    taken       = 1'b0;

    // count lands in the cycle after the move starts, before any low phase ends
    if (calc_r) begin
      steps_nxt = STEPS_W'(prod[PROD_W-1:DIV9_SHIFT]);
    end

    if (advance) begin
      case (cmd_r)
        CMD_TICK: begin
          unique case (phase_r)
            PH_IDLE: begin
              if (pending_r) begin
                pending_nxt = 1'b0;
                if (delta == '0) begin
                  pos_nxt = pend_r;
                end else begin
                  dir_nxt  = delta[POS_W-1];
                  mag_nxt  = delta[POS_W-1] ? (~delta + POS_W'(1)) : delta;
                  calc_nxt = 1'b1;
                  if (setup_r == '0) begin
                    step_nxt  = 1'b1;
                    tick_nxt  = half_eff;
                    phase_nxt = PH_HIGH;
                  end else begin
                    tick_nxt  = HALF_W'(setup_r);
                    phase_nxt = PH_SETUP;
                  end
                end
              end
            end
            PH_SETUP: begin
              tick_nxt = tick_dec;
              if (tick_dec == '0) begin
                step_nxt  = 1'b1;
                tick_nxt  = half_eff;
                phase_nxt = PH_HIGH;
              end
            end
            PH_HIGH: begin
              tick_nxt = tick_dec;
              if (tick_dec == '0) begin
                step_nxt  = 1'b0;
                tick_nxt  = half_eff;
                phase_nxt = PH_LOW;
              end
            end
            PH_LOW: begin
              tick_nxt = tick_dec;
              if (tick_dec == '0) begin
                steps_nxt = steps_dec;
                if (steps_dec == '0) begin
                  pos_nxt   = pend_r;
                  phase_nxt = PH_IDLE;
                end else begin
                  step_nxt  = 1'b1;
                  tick_nxt  = half_eff;
                  phase_nxt = PH_HIGH;
                end
              end
            end
            default: phase_nxt = PH_IDLE;
          endcase
        end
        CMD_FRAME: begin
          // empty frames and frames during a move are dropped
          if (cnt_r != '0 && phase_r == PH_IDLE) begin
            pend_nxt    = cnt_r[1] ? {b0_r, b1_r} : POS_W'(b0_r);
            pending_nxt = 1'b1;
            taken       = 1'b1;
          end
        end
        CMD_READ: reply = 1'b1;
        default: ;
      endcase
    end

    out_data_nxt = {{(OUT_DATA_W - POS_W - 3){1'b0}}, pos_nxt,
                    (phase_nxt != PH_IDLE), dir_nxt, step_nxt};
    out_user_nxt = {taken, reply};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r    <= HALF_RST;
      setup_r   <= SETUP_RST;
      in_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
      phase_r   <= PH_IDLE;
      pos_r     <= '0;
      pend_r    <= '0;
      pending_r <= 1'b0;
      tick_r    <= '0;
      steps_r   <= '0;
      dir_r     <= 1'b0;
      step_r    <= 1'b0;
      calc_r    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_IDX_HALF) begin
          half_r <= cfg_data[HALF_W-1:0];
        end else if (cfg_index == CFG_IDX_SETUP) begin
          setup_r <= cfg_data[SETUP_W-1:0];
        end
      end

      if (in_tready) begin
        in_v_r <= in_tvalid;
      end

      if (advance) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end

      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      pend_r    <= pend_nxt;
      pending_r <= pending_nxt;
      tick_r    <= tick_nxt;
      steps_r   <= steps_nxt;
      dir_r     <= dir_nxt;
      step_r    <= step_nxt;
      calc_r    <= calc_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      cmd_r <= in_tuser[CMD_W-1:0];
      cnt_r <= in_tdata[CNT_W-1:0];
      b0_r  <= in_tdata[CNT_W +: BYTE_W];
      b1_r  <= in_tdata[CNT_W+BYTE_W +: BYTE_W];
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
    mag_r <= mag_nxt;
  end

  // step pin is low whenever no move runs
  a_step_low_idle: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> !step_r)
    else $error("step pin high while idle");

  // a pending target only exists while idle
  a_pending_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> phase_r == PH_IDLE)
    else $error("target pending during a move");

  // step count is loaded before any low phase runs
  a_steps_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_LOW |-> steps_r != '0)
    else $error("low phase with no steps left");

  // divide result is only ever due while a move runs
  a_calc_moving: assert property (@(posedge clk) disable iff (!rst_n)
    calc_r |-> phase_r != PH_IDLE)
    else $error("step count load outside a move");

endmodule

[tb/sv/stepper_absolute_position_mover_test.sv]
// Testbench for the absolute position stepper mover.
// A predictor in this module tracks position, pending target, pulse phase and
// counters; every accepted request pushes the pin snapshot it should produce,
// and the result monitor compares each returned snapshot with the oldest one.
module stepper_absolute_position_mover_test;
  import sapm_pkg::*;

  // byte_count codes and unused config / command codes
  localparam logic [CNT_W-1:0]     CNT_EMPTY = 2'd0;
  localparam logic [CNT_W-1:0]     CNT_ONE   = 2'd1;
  localparam logic [CNT_W-1:0]     CNT_TWO   = 2'd2;
  localparam logic [CNT_W-1:0]     CNT_OVER  = 2'd3;  // saturated count, acts as two
  localparam logic [CMD_W-1:0]     CMD_SPARE = 2'd3;  // no effect
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

  localparam int QUIET_LIMIT  = 1000;  // cycles without any handshake
  localparam int RANDOM_ITEMS = 300;
  localparam int TAIL_CYCLES  = 10;    // two-stage pipe plus margin

  typedef enum logic [1:0] {MOTION_IDLE, MOTION_SETUP, MOTION_HIGH, MOTION_LOW} motion_e;

  typedef struct packed {
    logic              step;
    logic              dir;
    logic              moving;
    logic [POS_W-1:0]  pos;
    logic              reply;
    logic              taken;
  } pin_snapshot_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  stepper_absolute_position_mover DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor state (mirrors the block after reset)
  // ---------------------------------------------------------------------------
  logic [HALF_W-1:0]  cfg_half      = HALF_RST;
  logic [SETUP_W-1:0] cfg_setup     = SETUP_RST;
  logic [POS_W-1:0]   pos_now       = '0;
  logic [POS_W-1:0]   goal          = '0;
  logic               goal_waiting  = 1'b0;
  motion_e            motion        = MOTION_IDLE;
  logic [15:0]        phase_ticks   = '0;
  logic [STEPS_W-1:0] steps_to_go   = '0;
  logic               dir_pin       = 1'b0;
  logic               step_pin      = 1'b0;

  pin_snapshot_t expected_pins[$];
  int            mismatches    = 0;
  int            requests_sent = 0;
  int            quiet_cycles  = 0;
  bit            idling_on     = 1'b1;

  // zero half period behaves as one
  function automatic logic [15:0] half_ticks_now();
    return (cfg_half == '0) ? 16'd1 : cfg_half;
  endfunction

  function automatic void start_pulse();
    step_pin    = 1'b1;
    phase_ticks = half_ticks_now();
    motion      = MOTION_HIGH;
  endfunction

  // One microsecond tick: start a pending move when idle, else count the phase down.
  function automatic void advance_tick();
    logic [POS_W-1:0] diff;
    int unsigned      mag;
    if (motion == MOTION_IDLE) begin
      if (goal_waiting) begin
        goal_waiting = 1'b0;
        diff = goal - pos_now;
        if (diff == '0) begin
          pos_now = goal;              // zero difference: no move, dir kept
        end else begin
          dir_pin     = diff[15];
          mag         = diff[15] ? (32'h10000 - diff) : diff;
          steps_to_go = STEPS_W'((40 * mag + 4) / 9);
          phase_ticks = 16'(cfg_setup);
          motion      = MOTION_SETUP;
          if (phase_ticks == '0) start_pulse();
        end
      end
      return;
    end
    if (phase_ticks != '0) phase_ticks--;
    if (phase_ticks != '0) return;
    case (motion)
      MOTION_SETUP: start_pulse();
      MOTION_HIGH: begin
        step_pin    = 1'b0;
        phase_ticks = half_ticks_now();
        motion      = MOTION_LOW;
      end
      default: begin
        if (steps_to_go != '0) steps_to_go--;
        if (steps_to_go == '0) begin
          pos_now = goal;
          motion  = MOTION_IDLE;
        end else begin
          start_pulse();
        end
      end
    endcase
  endfunction

  function automatic pin_snapshot_t predict_request(logic [CMD_W-1:0] cmd,
                                                    logic [CNT_W-1:0] cnt,
                                                    logic [7:0] b0, logic [7:0] b1);
    pin_snapshot_t p;
    p.reply = 1'b0;
    p.taken = 1'b0;
    case (cmd)
      CMD_TICK: advance_tick();
      CMD_FRAME: begin
        // frames count only while idle and non-empty
        if (cnt != CNT_EMPTY && motion == MOTION_IDLE) begin
          goal         = (cnt == CNT_ONE) ? {8'd0, b0} : {b0, b1};
          goal_waiting = 1'b1;
          p.taken      = 1'b1;
        end
      end
      CMD_READ: p.reply = 1'b1;
      default: ;
    endcase
    p.step   = step_pin;
    p.dir    = dir_pin;
    p.moving = (motion != MOTION_IDLE);
    p.pos    = pos_now;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, result-side backpressure, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // out_tready drops for random-length bursts while idling is enabled
  initial begin : ready_driver
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (idling_on && hold == 0 && $urandom_range(0, 5) == 0) hold = $urandom_range(1, 4);
      if (hold != 0) begin
        out_tready <= 1'b0;
        hold--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    do @(posedge clk); while (quiet_cycles < QUIET_LIMIT);
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result monitor
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, pin_snapshot_t want, pin_snapshot_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: want step=%0b dir=%0b moving=%0b pos=%0d reply=%0b taken=%0b",
               what, want.step, want.dir, want.moving, $signed(want.pos), want.reply,
               want.taken,
               "  got step=%0b dir=%0b moving=%0b pos=%0d reply=%0b taken=%0b",
               got.step, got.dir, got.moving, $signed(got.pos), got.reply, got.taken);
  endtask

  always @(posedge clk) begin
    pin_snapshot_t got;
    pin_snapshot_t want;
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (out_tvalid && out_tready) begin
        got.step   = out_tdata[0];
        got.dir    = out_tdata[1];
        got.moving = out_tdata[2];
        got.pos    = out_tdata[18:3];
        got.reply  = out_tuser[0];
        got.taken  = out_tuser[1];
        if (expected_pins.size() == 0) begin
          report_mismatch("result with no request outstanding", '0, got);
        end else begin
          want = expected_pins.pop_front();
          if (got !== want) report_mismatch("result mismatch", want, got);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // in_tvalid stays high after a handshake so back-to-back requests need no
  // lowering; anything that waits calls release_input first.
  task automatic send_request(logic [CMD_W-1:0] cmd, logic [CNT_W-1:0] cnt,
                              logic [7:0] b0, logic [7:0] b1);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= IN_DATA_W'({b1, b0, cnt});
    do @(posedge clk); while (!in_tready);
    expected_pins.push_back(predict_request(cmd, cnt, b0, b1));
    requests_sent++;
  endtask

  task automatic release_input();
    in_tvalid <= 1'b0;
  endtask

  task automatic send_tick();
    send_request(CMD_TICK, CNT_W'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic send_target(logic [POS_W-1:0] target, logic [CNT_W-1:0] cnt);
    if (cnt == CNT_ONE)
      send_request(CMD_FRAME, cnt, target[7:0], 8'($urandom));
    else
      send_request(CMD_FRAME, cnt, target[15:8], target[7:0]);
  endtask

  // read, unused command, empty frame, or a frame that a running move drops
  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: send_request(CMD_READ, CNT_W'($urandom), 8'($urandom), 8'($urandom));
      1: send_request(CMD_SPARE, CNT_W'($urandom), 8'($urandom), 8'($urandom));
      2: send_request(CMD_FRAME, CNT_EMPTY, 8'($urandom), 8'($urandom));
      default: begin
        if (motion != MOTION_IDLE)
          send_request(CMD_FRAME, CNT_W'($urandom_range(1, 3)), 8'($urandom), 8'($urandom));
        else
          send_request(CMD_READ, CNT_W'($urandom), 8'($urandom), 8'($urandom));
      end
    endcase
  endtask

  task automatic tick_until_still();
    while (motion != MOTION_IDLE || goal_waiting) send_tick();
  endtask

  task automatic move_to(logic [POS_W-1:0] target);
    send_target(target, CNT_TWO);
    tick_until_still();
  endtask

  // hold off new requests until every result is back
  task automatic wait_results_drained();
    release_input();
    do @(posedge clk); while (expected_pins.size() != 0);
  endtask

  // config writes go in only with the pipe empty
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    wait_results_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_IDX_HALF:  cfg_half  = value;
      CFG_IDX_SETUP: cfg_setup = value[SETUP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_random_setting(logic [CFG_IDX_W-1:0] idx);
    case (idx)
      CFG_IDX_HALF:  write_register(idx, CFG_DATA_W'($urandom_range(0, 3)));
      CFG_IDX_SETUP: write_register(idx, ($urandom_range(0, 4) == 0) ?
                                         CFG_DATA_W'($urandom_range(7, 40)) :
                                         CFG_DATA_W'($urandom_range(0, 6)));
      default:       write_register(idx, CFG_DATA_W'($urandom));
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Requests that touch nothing, then one move with the reset setup time;
  // the half period is shortened during setup and lands at the first pulse.
  task automatic test_reset_state();
    send_request(CMD_READ, CNT_EMPTY, 8'h00, 8'h00);
    send_tick();                                   // idle, nothing pending
    send_request(CMD_SPARE, CNT_OVER, 8'hFF, 8'hFF);
    send_request(CMD_FRAME, CNT_EMPTY, 8'hFF, 8'h00);
    send_target(16'd1, CNT_TWO);
    send_tick();                                   // 20-tick setup starts
    repeat (5) send_tick();
    write_register(CFG_IDX_HALF, 16'd1);
    tick_until_still();
  endtask

  // Register extremes, out-of-range indexes, truncated setup, zero half period.
  task automatic test_config_extremes();
    write_register(CFG_IDX_SPARE_A, 16'h0000);
    write_register(CFG_IDX_SPARE_B, 16'hFFFF);
    write_register(CFG_IDX_HALF, 16'd1);
    write_register(CFG_IDX_SETUP, 16'd0);          // first pulse on the starting tick
    move_to(pos_now + 16'd2);
    write_register(CFG_IDX_SETUP, 16'd37);         // longer setup
    move_to(pos_now - 16'd1);
    write_register(CFG_IDX_HALF, 16'd0);           // acts as one
    write_register(CFG_IDX_SETUP, 16'hFC02);       // upper bits fall off
    move_to(pos_now + 16'd1);
  endtask

  // One-byte and saturated frames, replacement, drop while moving, zero move.
  task automatic test_frame_rules();
    send_target(16'h00FF, CNT_ONE);
    send_target(pos_now - 16'd3, CNT_OVER);        // replaces the pending target
    send_tick();
    send_request(CMD_FRAME, CNT_TWO, 8'h12, 8'h34); // dropped, move running
    tick_until_still();
    send_target(pos_now, CNT_TWO);                 // zero difference keeps dir high
    send_tick();
    send_request(CMD_READ, CNT_ONE, 8'h5A, 8'hA5);
    move_to(16'hFFFE);
    move_to(16'h0000);
  endtask

  // Short moves with random content, noise, retargeting and mid-move retunes.
  task automatic test_random_traffic();
    logic [POS_W-1:0] target;
    logic [CNT_W-1:0] cnt;
    int               delta;
    int               stop_at;
    stop_at = requests_sent + RANDOM_ITEMS;
    while (requests_sent < stop_at) begin
      if ($urandom_range(0, 5) == 0) begin
        write_random_setting(CFG_IDX_HALF);
        write_random_setting(CFG_IDX_SETUP);
      end
      if ($urandom_range(0, 4) == 0) send_noise();
      if ($urandom_range(0, 3) == 0) send_target(POS_W'($urandom), CNT_TWO);
      if ($urandom_range(0, 5) == 0) delta = $urandom_range(0, 24) - 12;
      else delta = $urandom_range(0, 6) - 3;
      target = pos_now + POS_W'(delta);
      if (target < 16'd256 && $urandom_range(0, 1) == 1) cnt = CNT_ONE;
      else cnt = $urandom_range(0, 1) ? CNT_TWO : CNT_OVER;
      send_target(target, cnt);
      while (motion != MOTION_IDLE || goal_waiting) begin
        case ($urandom_range(0, 15))
          0: send_noise();
          1: begin
            if (motion != MOTION_IDLE) write_random_setting(CFG_IDX_W'($urandom));
            else send_tick();
          end
          default: send_tick();
        endcase
      end
    end
  endtask

  // Long half period, cut short by a write that lands at the next phase load.
  task automatic test_half_period_retune();
    write_register(CFG_IDX_SETUP, 16'd0);
    write_register(CFG_IDX_HALF, 16'd50);
    send_target(pos_now + 16'd1, CNT_TWO);
    send_tick();                                   // high phase of 50 ticks
    send_tick();
    write_register(CFG_IDX_HALF, 16'd1);
    tick_until_still();
  endtask

  // Back-to-back ticks through two moves in opposite directions.
  task automatic test_full_rate_moves();
    write_register(CFG_IDX_HALF, 16'd1);
    write_register(CFG_IDX_SETUP, 16'd3);
    move_to(pos_now + 16'd8);
    move_to(pos_now - 16'd8);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_config_extremes();
    test_frame_rules();
    test_random_traffic();

    idling_on = 1'b0;                              // last moves run at full rate
    test_half_period_retune();
    test_full_rate_moves();

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_pins.size() != 0) begin
      $display("%0d results never arrived", expected_pins.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[stepper_absolute_position_mover.f]
sv/sapm_pkg.sv
sv/stepper_absolute_position_mover.sv
tb/sv/stepper_absolute_position_mover_test.sv
